// ===== rtl/swf_pkg.sv =====
// shared constants, codes and payload types for the 1d shallow-water nodal flux block
`timescale 1ns / 1ps
package swf_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int THR_W     = DATA_W - 1;
    localparam int CFG_IDX_W = 1;

    // pipeline depths: divider has a setup stage plus one stage per quotient bit
    localparam int DIV_LAT    = DATA_W + 1;
    localparam int PRES_LAT   = 4;
    localparam int PRES_DLY   = DIV_LAT - PRES_LAT;
    localparam int LAT_CYCLES = DATA_W + 4;

    localparam logic [THR_W-1:0] WET_THR_RST = THR_W'(66);
    localparam logic [THR_W-1:0] GRAVITY_RST = THR_W'(642908);

    localparam logic [CFG_IDX_W-1:0] CFG_WET_THR = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY = CFG_IDX_W'(1);

    localparam logic [1:0] MODE_WET   = 2'd0;
    localparam logic [1:0] MODE_FLOOD = 2'd1;
    localparam logic [1:0] MODE_DRY   = 2'd2;

    localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [DATA_W-1:0] depth;
        logic signed [DATA_W-1:0] discharge;
        logic signed [DATA_W-1:0] bed_level;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] mass_flux;
        logic signed [DATA_W-1:0] momentum_flux;
    } t_out_item;

    // per-node control that rides along the divider pipeline
    typedef struct packed {
        logic [1:0]               mode;
        logic signed [DATA_W-1:0] discharge;
        logic                     wet;
    } t_side;

endpackage

// ===== rtl/swf_pressure.sv =====
// pressure term pipeline: 0.5*g*(h*h - z*z) with saturation, four register stages
`timescale 1ns / 1ps
module swf_pressure (
    input  logic                               i_clk,
    input  logic [2*swf_pkg::DATA_W-1:0]       i_hh,
    input  logic [2*swf_pkg::DATA_W-1:0]       i_zz,
    input  logic [swf_pkg::DATA_W-2:0]         i_gravity,
    output logic signed [swf_pkg::DATA_W-1:0]  o_press
);

    localparam int W = swf_pkg::DATA_W;
    localparam int F = swf_pkg::FRAC_W;

    logic [2*W-F-1:0] hsh;
    logic [2*W-F-1:0] zsh;
    logic [W-2:0]     hs;
    logic [W-2:0]     zs;

    logic [W-2:0]     r_hs;
    logic [W-2:0]     r_zs;
    logic [W-2:0]     r_g1;

    logic             neg2;
    logic [W-2:0]     mag2;
    logic             r_neg2;
    logic [W-2:0]     r_mag2;
    logic [W-2:0]     r_g2;

    logic             r_neg3;
    logic [2*W-3:0]   r_prod3;

    logic [2*W-F-4:0]          sh;
    logic                      big;
    logic signed [W-1:0]       press;
    logic signed [W-1:0]       r_press;

    // stage 1: drop fraction bits, clamp each square
    assign hsh = i_hh[2*W-1:F];
    assign zsh = i_zz[2*W-1:F];
    assign hs  = (|hsh[2*W-F-1:W-1]) ? '1 : hsh[W-2:0];
    assign zs  = (|zsh[2*W-F-1:W-1]) ? '1 : zsh[W-2:0];

    // stage 2: signed difference as sign and magnitude
    assign neg2 = r_zs > r_hs;
    assign mag2 = neg2 ? (r_zs - r_hs) : (r_hs - r_zs);

    // stage 4: shift by fraction plus one for the half, clamp with sign
    assign sh  = r_prod3[2*W-3:F+1];
    assign big = |sh[2*W-F-4:W-1];

    always_comb begin
        if (r_neg3) begin
            press = big ? swf_pkg::SMIN : (~{1'b0, sh[W-2:0]} + 1'b1);
        end else begin
            press = big ? swf_pkg::SMAX : {1'b0, sh[W-2:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_hs    <= hs;
        r_zs    <= zs;
        r_g1    <= i_gravity;
        r_neg2  <= neg2;
        r_mag2  <= mag2;
        r_g2    <= r_g1;
        r_neg3  <= r_neg2;
        r_prod3 <= r_g2 * r_mag2;
        r_press <= press;
    end

    assign o_press = r_press;

endmodule

// ===== rtl/swf_divider.sv =====
// pipelined restoring divider, one quotient bit per stage, with overflow flag
`timescale 1ns / 1ps
module swf_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  swf_pkg::t_side                i_side,
    input  logic [2*swf_pkg::DATA_W-1:0]  i_dividend,
    input  logic [swf_pkg::DATA_W-2:0]    i_divisor,
    output logic                          o_vld,
    output swf_pkg::t_side                o_side,
    output logic [swf_pkg::DATA_W-1:0]    o_quot,
    output logic                          o_ovf
);

    localparam int W = swf_pkg::DATA_W;

    logic                 r_vld  [0:W];
    swf_pkg::t_side       r_side [0:W];
    logic [W-1:0]         r_rem  [0:W];
    logic [W-1:0]         r_low  [0:W];
    logic [W-1:0]         r_quo  [0:W];
    logic [W-2:0]         r_div  [0:W];
    logic                 r_ovf  [0:W];

    // setup: high half is the first partial remainder; quotient too wide if it is not below h
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= i_side;
        r_rem[0]  <= i_dividend[2*W-1:W];
        r_low[0]  <= i_dividend[W-1:0];
        r_quo[0]  <= '0;
        r_div[0]  <= i_divisor;
        r_ovf[0]  <= i_dividend[2*W-1:W] >= {1'b0, i_divisor};
    end

    for (genvar k = 1; k <= W; k++) begin : g_step
        logic [W:0] rem2;
        logic [W:0] sub;
        logic       ge;

        assign rem2 = {r_rem[k-1], r_low[k-1][W-1]};
        assign sub  = rem2 - {2'b00, r_div[k-1]};
        assign ge   = rem2 >= {2'b00, r_div[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[k] <= r_side[k-1];
            r_rem[k]  <= ge ? sub[W-1:0] : rem2[W-1:0];
            r_low[k]  <= {r_low[k-1][W-2:0], 1'b0};
            r_quo[k]  <= {r_quo[k-1][W-2:0], ge};
            r_div[k]  <= r_div[k-1];
            r_ovf[k]  <= r_ovf[k-1];
        end
    end

    assign o_vld  = r_vld[W];
    assign o_side = r_side[W];
    assign o_quot = r_quo[W];
    assign o_ovf  = r_ovf[W];

endmodule

// ===== rtl/shallow_water_1d_nodal_flux_top.sv =====
// top level of the 1d shallow-water nodal flux pipeline
`timescale 1ns / 1ps
// usage
// - input channel: a node (mode, depth, discharge, bed_level) transfers at a rising edge
//   with start high and busy low; busy is low whenever reset is released, so a node can
//   be offered every cycle
// - result channel: o_strobe marks o_result for exactly one cycle; the receiver must take
//   it then, there is no back-pressure
// - path: an accepted node passes the stage 1 and stage 2 registers, the divider and the
//   output register before its result shows on o_result with o_strobe
// - throughput: one node per cycle; the depth is set by the q*q/h divider, which
//   resolves one quotient bit per pipeline stage (32 stages plus setup)
// - pressure path runs in four stages and waits in a delay line to meet the quotient
// - config port: i_cfg_we writes i_cfg_wdata into the register picked by i_cfg_idx
//   (0 wet threshold, 1 gravity); write only while no node is in flight
// - reset (synchronous, active low) drops every node in flight, restores threshold 66
//   and gravity 9.81 in q16.16, and holds busy high
module shallow_water_1d_nodal_flux_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  swf_pkg::t_in_item                   i_item,
    output logic                                o_strobe,
    output swf_pkg::t_out_item                  o_result,
    input  logic                                i_cfg_we,
    input  logic [swf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [swf_pkg::THR_W-1:0]           i_cfg_wdata
);

    localparam int W = swf_pkg::DATA_W;
    localparam int D = swf_pkg::PRES_DLY;

    // config registers
    logic [W-2:0] r_wet_thr;
    logic [W-2:0] r_gravity;

    // stage 1: magnitudes, wet test, gravity select
    logic           acc;
    logic [W-1:0]   n_mag_h;
    logic [W-1:0]   n_mag_z;
    logic [W-1:0]   n_mag_q;
    swf_pkg::t_side n_side;

    logic           r_s1_vld;
    swf_pkg::t_side r_s1_side;
    logic [W-1:0]   r_s1_mag_h;
    logic [W-1:0]   r_s1_mag_z;
    logic [W-1:0]   r_s1_mag_q;
    logic [W-2:0]   r_s1_div;
    logic [W-2:0]   r_s1_g;

    // stage 2: the three squares
    logic           r_s2_vld;
    swf_pkg::t_side r_s2_side;
    logic [2*W-1:0] r_s2_hh;
    logic [2*W-1:0] r_s2_zz;
    logic [2*W-1:0] r_s2_qq;
    logic [W-2:0]   r_s2_div;
    logic [W-2:0]   r_s2_g;

    // pressure and divider outputs
    logic signed [W-1:0] press;
    logic signed [W-1:0] r_p_dly [0:D-1];
    logic                dv_vld;
    swf_pkg::t_side      dv_side;
    logic [W-1:0]        dv_quot;
    logic                dv_ovf;

    // output stage
    logic signed [W-1:0] p_al;
    logic signed [W-1:0] q_sat;
    logic signed [W:0]   sum;
    logic signed [W-1:0] mom_wet;
    swf_pkg::t_out_item  n_out;
    logic                r_out_vld;
    swf_pkg::t_out_item  r_out;

    assign busy = ~i_rst_n;
    assign acc  = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wet_thr <= swf_pkg::WET_THR_RST;
            r_gravity <= swf_pkg::GRAVITY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                swf_pkg::CFG_WET_THR: r_wet_thr <= i_cfg_wdata;
                swf_pkg::CFG_GRAVITY: r_gravity <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // magnitudes; the most negative value maps to 2^(W-1), still exact in W bits
    assign n_mag_h = i_item.depth[W-1]     ? (~i_item.depth + 1'b1)     : i_item.depth;
    assign n_mag_z = i_item.bed_level[W-1] ? (~i_item.bed_level + 1'b1) : i_item.bed_level;
    assign n_mag_q = i_item.discharge[W-1] ? (~i_item.discharge + 1'b1) : i_item.discharge;

    always_comb begin
        n_side.mode      = i_item.mode;
        n_side.discharge = i_item.discharge;
        // wet only for a depth above the threshold, so the divisor of a wet node is always positive
        n_side.wet       = $signed(i_item.depth) > $signed({1'b0, r_wet_thr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= acc;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_side  <= n_side;
        r_s1_mag_h <= n_mag_h;
        r_s1_mag_z <= n_mag_z;
        r_s1_mag_q <= n_mag_q;
        r_s1_div   <= i_item.depth[W-2:0];
        // partial-wet flood nodes see no gravity
        r_s1_g     <= (i_item.mode == swf_pkg::MODE_FLOOD) ? '0 : r_gravity;

        r_s2_side  <= r_s1_side;
        r_s2_hh    <= r_s1_mag_h * r_s1_mag_h;
        r_s2_zz    <= r_s1_mag_z * r_s1_mag_z;
        r_s2_qq    <= r_s1_mag_q * r_s1_mag_q;
        r_s2_div   <= r_s1_div;
        r_s2_g     <= r_s1_g;
    end

    swf_pressure u_pressure (
        .i_clk     (i_clk),
        .i_hh      (r_s2_hh),
        .i_zz      (r_s2_zz),
        .i_gravity (r_s2_g),
        .o_press   (press)
    );

    swf_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (r_s2_vld),
        .i_side     (r_s2_side),
        .i_dividend (r_s2_qq),
        .i_divisor  (r_s2_div),
        .o_vld      (dv_vld),
        .o_side     (dv_side),
        .o_quot     (dv_quot),
        .o_ovf      (dv_ovf)
    );

    // hold the pressure term until the quotient of the same node is out
    always_ff @(posedge i_clk) begin
        r_p_dly[0] <= press;
        for (int k = 1; k < D; k++) begin
            r_p_dly[k] <= r_p_dly[k-1];
        end
    end

    assign p_al = r_p_dly[D-1];

    // clamp the quotient, then add pressure with saturation; quotient is never negative
    assign q_sat   = (dv_ovf || dv_quot[W-1]) ? swf_pkg::SMAX : $signed(dv_quot);
    assign sum     = {p_al[W-1], p_al} + {1'b0, q_sat};
    assign mom_wet = (sum[W] != sum[W-1]) ? swf_pkg::SMAX : sum[W-1:0];

    always_comb begin
        unique case (dv_side.mode)
            swf_pkg::MODE_DRY: begin
                n_out.mass_flux     = '0;
                n_out.momentum_flux = '0;
            end
            default: begin
                n_out.mass_flux     = dv_side.wet ? dv_side.discharge : '0;
                n_out.momentum_flux = dv_side.wet ? mom_wet : p_al;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_strobe = r_out_vld;
    assign o_result = r_out;

endmodule

// ===== rtl/swf_checker.sv =====
// port-level checks for the nodal flux block, bound to the top level
`timescale 1ns / 1ps
module swf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input swf_pkg::t_in_item  i_item,
    input logic               o_strobe,
    input swf_pkg::t_out_item o_result
);

    localparam int L = swf_pkg::LAT_CYCLES;
    localparam int W = swf_pkg::DATA_W;

    // every result comes from a matching earlier input transfer
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, L))
        else $error("result strobe without matching input transfer");

    // every transfer yields its result
    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##L o_strobe)
        else $error("input transfer produced no result");

    // mass flux is either zero or the node's own discharge
    a_mass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.mass_flux == '0 ||
                      o_result.mass_flux == $past(i_item.discharge, L)))
        else $error("mass flux is neither zero nor the discharge");

    // dry nodes give zero for both fluxes
    a_dry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_item.mode == swf_pkg::MODE_DRY, L)) |->
            (o_result.mass_flux == '0 && o_result.momentum_flux == '0))
        else $error("dry node with nonzero flux");

    // flood node with non-positive depth: no gravity and never wet, so all zero
    a_flood_dry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_item.mode == swf_pkg::MODE_FLOOD &&
                           (i_item.depth[W-1] || i_item.depth == '0), L)) |->
            (o_result.mass_flux == '0 && o_result.momentum_flux == '0))
        else $error("flood node without water gave nonzero flux");

endmodule

bind shallow_water_1d_nodal_flux_top swf_checker u_swf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
